[rtl/bia_pkg.sv]
// bia_pkg: shared types and constants for the bitwise integer alu
// holds the opcode enum, the sequencer states and the input/output word structs
// no dependencies
`timescale 1ns / 1ps

package bia_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CntWidth  = $clog2(DataWidth);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [2:0]                  opcode;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic                        divide_error;
  } out_word_t;

  // unit status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } unit_sts_t;

endpackage

[rtl/bia_iter_unit.sv]
// bia_iter_unit: shared adder plus shift registers under a small sequencer
// runs add/sub in one step, multiply and divide in one step per operand bit
// depends on bia_pkg
`timescale 1ns / 1ps

module bia_iter_unit
  import bia_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  word_i,
  input  logic      ack_i,
  output unit_sts_t sts_o,
  output out_word_t word_o
);

  localparam int unsigned W = DataWidth;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [W-1:0]         acc_q, acc_d;
  logic [W-1:0]         x_q, x_d;
  logic [W-1:0]         y_q, y_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 err_q, err_d;

  logic [W:0]   add_x, add_y, add_sum;
  logic         add_sub;
  logic [W-1:0] rem_shift;
  logic         div_ge;
  logic [W-1:0] in_a, in_b;

  assign in_a = word_i.operand_a;
  assign in_b = word_i.operand_b;

  // partial remainder shifted with the next dividend bit
  assign rem_shift = {acc_q[W-2:0], x_q[W-1]};

  // the one shared adder/subtractor
  always_comb begin
    add_x   = {1'b0, x_q};
    add_y   = {1'b0, y_q};
    add_sub = 1'b0;
    unique case (op_q)
      OP_ADD: begin
        add_sub = 1'b0;
      end
      OP_SUB: begin
        add_sub = 1'b1;
      end
      OP_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = {1'b0, x_q & {W{y_q[0]}}};
      end
      OP_DIV, OP_REM: begin
        add_x   = {1'b0, rem_shift};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = add_x + (add_y ^ {(W+1){add_sub}}) + {{W{1'b0}}, add_sub};
  assign div_ge  = ~add_sum[W];

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d     = in_a;
          y_d     = in_b;
          acc_d   = '0;
          err_d   = 1'b0;
          cnt_d   = CntWidth'(W - 1);
          state_d = ST_CALC;
          unique case (word_i.opcode)
            3'(OP_ADD): begin
              op_d  = OP_ADD;
              cnt_d = '0;
            end
            3'(OP_SUB): begin
              op_d  = OP_SUB;
              cnt_d = '0;
            end
            3'(OP_MUL): begin
              op_d = OP_MUL;
            end
            3'(OP_DIV), 3'(OP_REM): begin
              op_d = op_e'(word_i.opcode);
              if (in_b == '0 || in_b[W-1]) begin
                // nonpositive divisor
                err_d   = 1'b1;
                x_d     = '0;
                state_d = ST_DONE;
              end else if (in_a[W-1]) begin
                // negative dividend is below the divisor: quotient 0, remainder a
                x_d     = '0;
                acc_d   = in_a;
                state_d = ST_DONE;
              end
            end
            default: begin
              // unused opcode gives 0
              op_d    = OP_ADD;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CALC: begin
        unique case (op_q)
          OP_MUL: begin
            acc_d = add_sum[W-1:0];
            x_d   = {x_q[W-2:0], 1'b0};
            y_d   = {1'b0, y_q[W-1:1]};
          end
          OP_DIV, OP_REM: begin
            acc_d = div_ge ? add_sum[W-1:0] : rem_shift;
            x_d   = {x_q[W-2:0], div_ge};
          end
          default: begin
            acc_d = add_sum[W-1:0];
          end
        endcase
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    cnt_q <= cnt_d;
    err_q <= err_d;
  end

  assign sts_o.idle = (state_q == ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);

  assign word_o.result_value = (op_q == OP_DIV) ? x_q : acc_q;
  assign word_o.divide_error = err_q;

endmodule

[rtl/bitwise_integer_alu.sv]
// bitwise integer alu: add, subtract, shift-add multiply, restoring divide
// add/sub take one adder step, error/shortcut cases skip the adder, mul/div/rem take one step per operand bit
// the unit takes no new word until it is through with the last, held for mul/div by the 32 steps of the shared adder
// the output register frees the unit, so a new word is taken while a result waits
// reset: rst_ni async active low clears the sequencer and the output valid flag
`timescale 1ns / 1ps

module bitwise_integer_alu
  import bia_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  unit_sts_t unit_sts;
  out_word_t unit_word;

  logic      in_accept;
  logic      out_load;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  // input side: a word is taken only while the unit sits idle
  assign in_stall_o = ~unit_sts.idle;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // finished result moves to the output register when it is empty or draining
  assign out_load = unit_sts.done & (~out_valid_q | ~out_stall_i);

  bia_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .word_i (in_data_i),
    .ack_i  (out_load),
    .sts_o  (unit_sts),
    .word_o (unit_word)
  );

  // output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= unit_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // an accepted word keeps the unit busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("unit took a word but did not go busy");

  // a finished result that can move must show up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("finished result was not loaded into the output register");

  // error results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.divide_error) |-> (out_data_o.result_value == '0))
    else $error("divide error with nonzero result");

endmodule
